### hdl/mcfp_pkg.sv
package mcfp_pkg;

   localparam int POS_SLOT_BITS   = 16;
   localparam int FIELD_SLOT_BITS = 12;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_POSITION_LIMIT = 3'd0,
      CSR_VELOCITY_LIMIT = 3'd1,
      CSR_TORQUE_LIMIT   = 3'd2,
      CSR_STIFFNESS_MIN  = 3'd3,
      CSR_STIFFNESS_MAX  = 3'd4,
      CSR_DAMPING_MIN    = 3'd5,
      CSR_DAMPING_MAX    = 3'd6
   } csr_index_type;

   localparam logic [30:0]        POSITION_LIMIT_RST = 31'd819200;
   localparam logic [30:0]        VELOCITY_LIMIT_RST = 31'd1966080;
   localparam logic [30:0]        TORQUE_LIMIT_RST   = 31'd655360;
   localparam logic signed [31:0] STIFFNESS_MIN_RST  = 32'sd0;
   localparam logic signed [31:0] STIFFNESS_MAX_RST  = 32'sd32768000;
   localparam logic signed [31:0] DAMPING_MIN_RST    = 32'sd0;
   localparam logic signed [31:0] DAMPING_MAX_RST    = 32'sd327680;

   typedef struct packed {
      logic [10:0]        motor_ident;
      logic signed [31:0] target_position;
      logic signed [31:0] target_velocity;
      logic signed [31:0] stiffness_gain;
      logic signed [31:0] damping_gain;
      logic signed [31:0] feedforward_torque;
   } req_type;

   typedef struct packed {
      logic [10:0] frame_ident;
      logic [63:0] frame_payload;
   } rsp_type;

endpackage

### hdl/mcfp_scale.sv
module mcfp_scale
   import mcfp_pkg::*;
#(
   parameter int BITS     = 12,
   parameter int DIV_BITS = 16
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic signed [31:0]       value,
   input  logic signed [32:0]       range_lo,
   input  logic signed [32:0]       range_hi,
   output logic [31+DIV_BITS:0]     numer,
   output logic [31:0]              span
);

   localparam logic [DIV_BITS-1:0] FULL = DIV_BITS'((1 << BITS) - 1);

   logic signed [32:0]      x_wide;
   logic signed [32:0]      clamp;
   logic signed [32:0]      diff;
   logic signed [32:0]      width;
   logic [31:0]             dist_in;
   logic [31:0]             span_in;
   logic [31:0]             dist_ff;
   logic [31:0]             span1_ff;
   logic [31+DIV_BITS:0]    numer_ff;
   logic [31:0]             span2_ff;

   always_comb begin
      x_wide = 33'(value);
      if (x_wide < range_lo) begin
         clamp = range_lo;
      end else if (x_wide > range_hi) begin
         clamp = range_hi;
      end else begin
         clamp = x_wide;
      end
      diff  = clamp - range_lo;
      width = range_hi - range_lo;
      // An empty range divides zero by one, which gives code zero.
      if (range_hi > range_lo) begin
         dist_in = diff[31:0];
         span_in = width[31:0];
      end else begin
         dist_in = 32'd0;
         span_in = 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dist_ff  <= dist_in;
         span1_ff <= span_in;
         numer_ff <= (32+DIV_BITS)'(dist_ff) * (32+DIV_BITS)'(FULL);
         span2_ff <= span1_ff;
      end
   end

   assign numer = numer_ff;
   assign span  = span2_ff;

endmodule

### hdl/mcfp_divider.sv
module mcfp_divider
   import mcfp_pkg::*;
#(
   parameter int DIV_BITS = 16
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [31+DIV_BITS:0]  numer,
   input  logic [31:0]           span,
   output logic [DIV_BITS-1:0]   quotient
);

   logic [31:0]          rem_ff  [DIV_BITS];
   logic [DIV_BITS-1:0]  low_ff  [DIV_BITS];
   logic [DIV_BITS-1:0]  quo_ff  [DIV_BITS];
   logic [31:0]          span_ff [DIV_BITS];

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
      logic [31:0]         rem_src;
      logic [DIV_BITS-1:0] low_src;
      logic [DIV_BITS-1:0] quo_src;
      logic [31:0]         span_src;
      logic [32:0]         trial;
      logic [32:0]         sub;
      logic                take;

      if (k == 0) begin : g_first
         assign rem_src  = numer[31+DIV_BITS:DIV_BITS];
         assign low_src  = numer[DIV_BITS-1:0];
         assign quo_src  = '0;
         assign span_src = span;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign low_src  = low_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign span_src = span_ff[k-1];
      end

      always_comb begin
         trial = {rem_src, low_src[DIV_BITS-1]};
         sub   = trial - {1'b0, span_src};
         take  = trial >= {1'b0, span_src};
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= take ? sub[31:0] : trial[31:0];
            low_ff[k]  <= {low_src[DIV_BITS-2:0], 1'b0};
            quo_ff[k]  <= {quo_src[DIV_BITS-2:0], take};
            span_ff[k] <= span_src;
         end
      end
   end

   assign quotient = quo_ff[DIV_BITS-1];

endmodule

### hdl/mit_command_frame_packer.sv
// Channel   Direction  Payload    Handshake
// req       in         req_type   req_valid / req_stall
// rsp       out        rsp_type   rsp_valid / rsp_stall
// csr       in         index+data csr_write_enable
//
// One command enters per cycle while req_stall is low; a frame leaves through the scale
// registers, the restoring divider, one quotient bit per stage, and the output register.
// The whole pipeline holds while a frame waits on rsp_stall; req_stall follows it.
// Reset is synchronous and clears the valid bits and sets the CSR registers to their defaults.
module mit_command_frame_packer
   import mcfp_pkg::*;
#(
   parameter int POSITION_BITS = 16,
   parameter int FIELD_BITS    = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int DIV_BITS = (POSITION_BITS > FIELD_BITS) ? POSITION_BITS : FIELD_BITS;
   localparam int DEPTH    = DIV_BITS + 2;

   logic [30:0]        pos_limit_ff;
   logic [30:0]        vel_limit_ff;
   logic [30:0]        trq_limit_ff;
   logic signed [31:0] kp_min_ff;
   logic signed [31:0] kp_max_ff;
   logic signed [31:0] kd_min_ff;
   logic signed [31:0] kd_max_ff;

   logic               vld_ff   [DEPTH];
   logic [10:0]        ident_ff [DEPTH];
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;
   logic               enable;

   logic [31+DIV_BITS:0] numer [5];
   logic [31:0]          span  [5];
   logic [DIV_BITS-1:0]  quo   [5];
   logic signed [31:0]   value [5];
   logic signed [32:0]   lo    [5];
   logic signed [32:0]   hi    [5];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_limit_ff <= POSITION_LIMIT_RST;
         vel_limit_ff <= VELOCITY_LIMIT_RST;
         trq_limit_ff <= TORQUE_LIMIT_RST;
         kp_min_ff    <= STIFFNESS_MIN_RST;
         kp_max_ff    <= STIFFNESS_MAX_RST;
         kd_min_ff    <= DAMPING_MIN_RST;
         kd_max_ff    <= DAMPING_MAX_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_POSITION_LIMIT: pos_limit_ff <= csr_wdata[30:0];
            CSR_VELOCITY_LIMIT: vel_limit_ff <= csr_wdata[30:0];
            CSR_TORQUE_LIMIT:   trq_limit_ff <= csr_wdata[30:0];
            CSR_STIFFNESS_MIN:  kp_min_ff    <= csr_wdata;
            CSR_STIFFNESS_MAX:  kp_max_ff    <= csr_wdata;
            CSR_DAMPING_MIN:    kd_min_ff    <= csr_wdata;
            CSR_DAMPING_MAX:    kd_max_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      value[0] = req_data.target_position;
      value[1] = req_data.target_velocity;
      value[2] = req_data.stiffness_gain;
      value[3] = req_data.damping_gain;
      value[4] = req_data.feedforward_torque;
      hi[0] = {2'b00, pos_limit_ff};
      hi[1] = {2'b00, vel_limit_ff};
      hi[2] = 33'(kp_max_ff);
      hi[3] = 33'(kd_max_ff);
      hi[4] = {2'b00, trq_limit_ff};
      lo[0] = -hi[0];
      lo[1] = -hi[1];
      lo[2] = 33'(kp_min_ff);
      lo[3] = 33'(kd_min_ff);
      lo[4] = -hi[4];
   end

   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;

   for (genvar i = 0; i < 5; i++) begin : g_lane
      mcfp_scale #(
         .BITS     ((i == 0) ? POSITION_BITS : FIELD_BITS),
         .DIV_BITS (DIV_BITS)
      ) u_scale (
         .clock    (clock),
         .enable   (enable),
         .value    (value[i]),
         .range_lo (lo[i]),
         .range_hi (hi[i]),
         .numer    (numer[i]),
         .span     (span[i])
      );

      mcfp_divider #(
         .DIV_BITS (DIV_BITS)
      ) u_divider (
         .clock    (clock),
         .enable   (enable),
         .numer    (numer[i]),
         .span     (span[i]),
         .quotient (quo[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < DEPTH; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_valid_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ident_ff[0] <= req_data.motor_ident;
         for (int k = 1; k < DEPTH; k++) begin
            ident_ff[k] <= ident_ff[k-1];
         end
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_comb begin
      rsp_data_in.frame_ident   = ident_ff[DEPTH-1];
      rsp_data_in.frame_payload = {POS_SLOT_BITS'(quo[0]),
                                   FIELD_SLOT_BITS'(quo[1]),
                                   FIELD_SLOT_BITS'(quo[2]),
                                   FIELD_SLOT_BITS'(quo[3]),
                                   FIELD_SLOT_BITS'(quo[4])};
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
